// ----- hw/rtl/pdsq_pkg.sv -----
// Shared constants, register codes and word types for the PD square-root torque law.
package pdsq_pkg;

   localparam int VALUE_W    = 32;
   localparam int GAIN_W     = 16;
   localparam int LIM_W      = 31;
   localparam int OUT_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int ERR_W      = VALUE_W + 1;
   localparam int ROOT_W     = (ERR_W + FRAC_W + 1) / 2;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int RAD_PAD    = RAD_W - ERR_W - FRAC_W;
   localparam int REM_W      = ROOT_W + 3;
   localparam int P_W        = GAIN_W + ERR_W;
   localparam int R_W        = GAIN_W + ROOT_W;
   localparam int D_W        = GAIN_W + VALUE_W;
   localparam int GE_W       = P_W + 1;
   localparam int TV_W       = D_W + 1;
   localparam int NET_W      = GE_W + 2;
   localparam int MAG_W      = NET_W - 1;
   localparam int GAIN_FRAC  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd5120;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd1280;
   localparam logic [GAIN_W-1:0]  ROOT_GAIN_RST   = 16'd256;
   localparam logic [VALUE_W-1:0] TARGET_POS_RST  = 32'd0;
   localparam logic [LIM_W-1:0]   ZERO_TOL_RST    = 31'd572;
   localparam logic [LIM_W-1:0]   TORQUE_LIM_RST  = 31'd655360;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN       = 3'd0,
      CSR_DERIV_GAIN      = 3'd1,
      CSR_ROOT_GAIN       = 3'd2,
      CSR_TARGET_POSITION = 3'd3,
      CSR_ZERO_TOLERANCE  = 3'd4,
      CSR_TORQUE_LIMIT    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [GAIN_W-1:0]  root_gain;
      logic [VALUE_W-1:0] target_position;
      logic [LIM_W-1:0]   zero_tolerance;
      logic [LIM_W-1:0]   torque_limit;
   } csr_regs_type;

   typedef struct packed {
      logic [ERR_W-1:0]   emag;
      logic [VALUE_W-1:0] vmag;
      logic               e_neg;
      logic               v_neg;
   } carry_type;

   typedef struct packed {
      carry_type          c;
      logic [RAD_W-1:0]   rad;
      logic [REM_W-1:0]   rem;
      logic [ROOT_W-1:0]  root;
   } root_word_type;

endpackage

// ----- hw/rtl/pdsq_front.sv -----
// Input register, deadband test, error and magnitude stages.
module pdsq_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pdsq_pkg::csr_regs_type                csr,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [pdsq_pkg::VALUE_W-1:0]   req_shaft_position,
   input  logic signed [pdsq_pkg::VALUE_W-1:0]   req_shaft_velocity,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output pdsq_pkg::root_word_type               out_word
);

   logic                                 in_v_ff;
   logic signed [pdsq_pkg::VALUE_W-1:0]  pos_ff;
   logic signed [pdsq_pkg::VALUE_W-1:0]  vel_ff;

   logic                                 a_v_ff;
   logic                                 keep_ff;
   logic                                 keep_in;
   logic signed [pdsq_pkg::ERR_W-1:0]    e_ff;
   logic signed [pdsq_pkg::ERR_W-1:0]    e_in;
   logic [pdsq_pkg::VALUE_W-1:0]         vmag_ff;
   logic [pdsq_pkg::VALUE_W-1:0]         vmag_in;
   logic                                 vneg_ff;

   logic                                 b_v_ff;
   pdsq_pkg::root_word_type              word_ff;
   pdsq_pkg::root_word_type              word_in;

   logic                                 ready0;
   logic                                 ready1;
   logic                                 ready2;

   logic signed [pdsq_pkg::VALUE_W-1:0]  tol_s;
   logic signed [pdsq_pkg::VALUE_W-1:0]  neg_tol;
   logic signed [pdsq_pkg::VALUE_W-1:0]  tgt_s;
   logic                                 e_neg;
   logic [pdsq_pkg::ERR_W-1:0]           emag;

   assign ready2    = !b_v_ff || out_ready;
   assign ready1    = !a_v_ff || !keep_ff || ready2;
   assign ready0    = !in_v_ff || ready1;
   assign req_stall = !ready0;

   // deadband on the raw position
   assign tol_s   = $signed({1'b0, csr.zero_tolerance});
   assign neg_tol = -tol_s;
   assign tgt_s   = $signed(csr.target_position);
   assign keep_in = !((pos_ff <= tol_s) && (pos_ff >= neg_tol));
   assign e_in    = $signed({pos_ff[pdsq_pkg::VALUE_W-1], pos_ff})
                  - $signed({tgt_s[pdsq_pkg::VALUE_W-1], tgt_s});
   assign vmag_in = vel_ff[pdsq_pkg::VALUE_W-1]
                  ? (~vel_ff + pdsq_pkg::VALUE_W'(1)) : vel_ff;

   assign e_neg = e_ff[pdsq_pkg::ERR_W-1];
   assign emag  = e_neg ? (~e_ff + pdsq_pkg::ERR_W'(1)) : e_ff;

   always_comb begin
      word_in         = '0;
      word_in.c.emag  = emag;
      word_in.c.vmag  = vmag_ff;
      word_in.c.e_neg = e_neg;
      word_in.c.v_neg = vneg_ff;
      word_in.rad     = {{pdsq_pkg::RAD_PAD{1'b0}}, emag, {pdsq_pkg::FRAC_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         a_v_ff  <= 1'b0;
         b_v_ff  <= 1'b0;
      end else begin
         if (ready0) in_v_ff <= req_valid;
         if (ready1) a_v_ff  <= in_v_ff;
         if (ready2) b_v_ff  <= a_v_ff && keep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready0) begin
         pos_ff <= req_shaft_position;
         vel_ff <= req_shaft_velocity;
      end
      if (ready1) begin
         keep_ff <= keep_in;
         e_ff    <= e_in;
         vmag_ff <= vmag_in;
         vneg_ff <= vel_ff[pdsq_pkg::VALUE_W-1];
      end
      if (ready2) word_ff <= word_in;
   end

   assign out_valid = b_v_ff;
   assign out_word  = word_ff;

endmodule

// ----- hw/rtl/pdsq_root_cell.sv -----
// One digit cell of the square-root chain: retires one root bit per stage.
module pdsq_root_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  pdsq_pkg::root_word_type  in_word,
   output logic                     out_valid,
   input  logic                     out_ready,
   output pdsq_pkg::root_word_type  out_word
);

   logic                            valid_ff;
   pdsq_pkg::root_word_type         word_ff;
   pdsq_pkg::root_word_type         word_in;
   logic [pdsq_pkg::REM_W-1:0]      rem_sh;
   logic [pdsq_pkg::REM_W-1:0]      trial;
   logic                            fits;

   assign in_ready = !valid_ff || out_ready;

   assign rem_sh = {in_word.rem[pdsq_pkg::REM_W-3:0],
                    in_word.rad[pdsq_pkg::RAD_W-1 -: 2]};
   assign trial  = {1'b0, in_word.root, 2'b01};
   assign fits   = rem_sh >= trial;

   always_comb begin
      word_in      = in_word;
      word_in.rad  = {in_word.rad[pdsq_pkg::RAD_W-3:0], 2'b00};
      word_in.rem  = fits ? (rem_sh - trial) : rem_sh;
      word_in.root = {in_word.root[pdsq_pkg::ROOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ----- hw/rtl/pdsq_back.sv -----
// Gain multiply, term sum, saturation, rounding and output register.
module pdsq_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pdsq_pkg::csr_regs_type               csr,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  pdsq_pkg::root_word_type              in_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pdsq_pkg::OUT_W-1:0]    rsp_torque_command
);

   logic m_v_ff, s_v_ff, n_v_ff, g_v_ff, r_v_ff, o_v_ff;
   logic m_rdy, s_rdy, n_rdy, g_rdy, r_rdy, o_rdy;

   logic [pdsq_pkg::P_W-1:0]            p_ff, p_in;
   logic [pdsq_pkg::R_W-1:0]            r_ff, r_in;
   logic [pdsq_pkg::D_W-1:0]            d_ff, d_in;
   logic                                m_eneg_ff, m_vneg_ff;

   logic [pdsq_pkg::GE_W-1:0]           ge_ff, ge_in;
   logic signed [pdsq_pkg::TV_W-1:0]    tv_ff, tv_in;
   logic                                s_eneg_ff;

   logic signed [pdsq_pkg::NET_W-1:0]   net_ff, net_in;
   logic signed [pdsq_pkg::NET_W-1:0]   tv_ext, ge_ext;

   logic [pdsq_pkg::MAG_W-1:0]          mag_ff, mag_in;
   logic                                g_neg_ff, g_neg_in;
   logic [pdsq_pkg::NET_W-1:0]          net_abs;

   logic [pdsq_pkg::LIM_W-1:0]          omag_ff, omag_in;
   logic                                r_neg_ff;
   logic [pdsq_pkg::MAG_W-1:0]          lim_sh;
   logic [pdsq_pkg::MAG_W-1:0]          rnd;
   logic                                sat;

   logic signed [pdsq_pkg::OUT_W-1:0]   torque_ff, torque_in;

   assign o_rdy    = !o_v_ff || !rsp_stall;
   assign r_rdy    = !r_v_ff || o_rdy;
   assign g_rdy    = !g_v_ff || r_rdy;
   assign n_rdy    = !n_v_ff || g_rdy;
   assign s_rdy    = !s_v_ff || n_rdy;
   assign m_rdy    = !m_v_ff || s_rdy;
   assign in_ready = m_rdy;

   assign p_in = csr.prop_gain * in_word.c.emag;
   assign r_in = csr.root_gain * in_word.root;
   assign d_in = csr.deriv_gain * in_word.c.vmag;

   // error terms oppose e, velocity term opposes the velocity
   assign ge_in = pdsq_pkg::GE_W'(p_ff) + pdsq_pkg::GE_W'(r_ff);
   assign tv_in = m_vneg_ff ? $signed({1'b0, d_ff}) : -$signed({1'b0, d_ff});

   assign tv_ext = {{(pdsq_pkg::NET_W - pdsq_pkg::TV_W){tv_ff[pdsq_pkg::TV_W-1]}}, tv_ff};
   assign ge_ext = $signed({{(pdsq_pkg::NET_W - pdsq_pkg::GE_W){1'b0}}, ge_ff});
   assign net_in = s_eneg_ff ? (tv_ext + ge_ext) : (tv_ext - ge_ext);

   assign g_neg_in = net_ff[pdsq_pkg::NET_W-1];
   assign net_abs  = g_neg_in ? (~net_ff + pdsq_pkg::NET_W'(1)) : net_ff;
   assign mag_in   = net_abs[pdsq_pkg::MAG_W-1:0];

   assign lim_sh  = pdsq_pkg::MAG_W'({csr.torque_limit, {pdsq_pkg::GAIN_FRAC{1'b0}}});
   assign sat     = mag_ff > lim_sh;
   assign rnd     = mag_ff + (pdsq_pkg::MAG_W'(1) << (pdsq_pkg::GAIN_FRAC - 1));
   assign omag_in = sat ? csr.torque_limit
                        : rnd[pdsq_pkg::LIM_W + pdsq_pkg::GAIN_FRAC - 1 : pdsq_pkg::GAIN_FRAC];

   assign torque_in = r_neg_ff ? $signed(~{1'b0, omag_ff} + pdsq_pkg::OUT_W'(1))
                               : $signed({1'b0, omag_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
         s_v_ff <= 1'b0;
         n_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         r_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (m_rdy) m_v_ff <= in_valid;
         if (s_rdy) s_v_ff <= m_v_ff;
         if (n_rdy) n_v_ff <= s_v_ff;
         if (g_rdy) g_v_ff <= n_v_ff;
         if (r_rdy) r_v_ff <= g_v_ff;
         if (o_rdy) o_v_ff <= r_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m_rdy) begin
         p_ff      <= p_in;
         r_ff      <= r_in;
         d_ff      <= d_in;
         m_eneg_ff <= in_word.c.e_neg;
         m_vneg_ff <= in_word.c.v_neg;
      end
      if (s_rdy) begin
         ge_ff     <= ge_in;
         tv_ff     <= tv_in;
         s_eneg_ff <= m_eneg_ff;
      end
      if (n_rdy) net_ff <= net_in;
      if (g_rdy) begin
         mag_ff   <= mag_in;
         g_neg_ff <= g_neg_in;
      end
      if (r_rdy) begin
         omag_ff  <= omag_in;
         r_neg_ff <= g_neg_ff;
      end
      if (o_rdy) torque_ff <= torque_in;
   end

   assign rsp_valid          = o_v_ff;
   assign rsp_torque_command = torque_ff;

endmodule

// ----- hw/rtl/pd_sqrt_homing_torque_law_core.sv -----
// Top level of the saturated PD torque law with a square-root error term.
//
//   channel  dir  handshake          word
//   req      in   req_valid/stall    shaft_position, shaft_velocity (s32 Q16.16)
//   rsp      out  rsp_valid/stall    torque_command (s32 Q16.16)
//   csr      in   csr_valid/ready    csr_index (3 b), csr_data (32 b)
//
// A result passes through 3 front stages (input register included), 25 root cells
// and 6 back stages.
// Back to back, while rsp_stall is low: one word per cycle enters and one result per cycle leaves.
// Words inside the position deadband are dropped in the front stages.
// Reset (synchronous) empties every stage and loads register defaults.
// A stage holds only while it is full and its successor holds; bubbles close up.
module pd_sqrt_homing_torque_law_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [pdsq_pkg::VALUE_W-1:0]     req_shaft_position,
   input  logic signed [pdsq_pkg::VALUE_W-1:0]     req_shaft_velocity,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [pdsq_pkg::OUT_W-1:0]       rsp_torque_command,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pdsq_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [pdsq_pkg::CSR_DATA_W-1:0]         csr_data
);

   pdsq_pkg::csr_regs_type            csr_ff;
   pdsq_pkg::csr_regs_type            csr_in;
   logic                              csr_we;

   pdsq_pkg::root_word_type           chain_word  [0:pdsq_pkg::ROOT_W];
   logic [pdsq_pkg::ROOT_W:0]         chain_valid;
   logic [pdsq_pkg::ROOT_W:0]         chain_ready;

   logic signed [pdsq_pkg::OUT_W-1:0] lim_s;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            pdsq_pkg::CSR_PROP_GAIN:
               csr_in.prop_gain = csr_data[pdsq_pkg::GAIN_W-1:0];
            pdsq_pkg::CSR_DERIV_GAIN:
               csr_in.deriv_gain = csr_data[pdsq_pkg::GAIN_W-1:0];
            pdsq_pkg::CSR_ROOT_GAIN:
               csr_in.root_gain = csr_data[pdsq_pkg::GAIN_W-1:0];
            pdsq_pkg::CSR_TARGET_POSITION:
               csr_in.target_position = csr_data[pdsq_pkg::VALUE_W-1:0];
            pdsq_pkg::CSR_ZERO_TOLERANCE:
               csr_in.zero_tolerance = csr_data[pdsq_pkg::LIM_W-1:0];
            pdsq_pkg::CSR_TORQUE_LIMIT:
               csr_in.torque_limit = csr_data[pdsq_pkg::LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.prop_gain       <= pdsq_pkg::PROP_GAIN_RST;
         csr_ff.deriv_gain      <= pdsq_pkg::DERIV_GAIN_RST;
         csr_ff.root_gain       <= pdsq_pkg::ROOT_GAIN_RST;
         csr_ff.target_position <= pdsq_pkg::TARGET_POS_RST;
         csr_ff.zero_tolerance  <= pdsq_pkg::ZERO_TOL_RST;
         csr_ff.torque_limit    <= pdsq_pkg::TORQUE_LIM_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   pdsq_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr                (csr_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_shaft_position (req_shaft_position),
      .req_shaft_velocity (req_shaft_velocity),
      .out_valid          (chain_valid[0]),
      .out_ready          (chain_ready[0]),
      .out_word           (chain_word[0])
   );

   for (genvar i = 0; i < pdsq_pkg::ROOT_W; i++) begin : g_root
      pdsq_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_word   (chain_word[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_word  (chain_word[i+1])
      );
   end

   pdsq_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr                (csr_ff),
      .in_valid           (chain_valid[pdsq_pkg::ROOT_W]),
      .in_ready           (chain_ready[pdsq_pkg::ROOT_W]),
      .in_word            (chain_word[pdsq_pkg::ROOT_W]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_torque_command (rsp_torque_command)
   );

   assign lim_s = $signed({1'b0, csr_ff.torque_limit});

   a_torque_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_torque_command <= lim_s) && (rsp_torque_command >= -lim_s))
      else $error("torque word exceeds limit");

   a_empty_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output stage");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
